// File: rtl/ffb_pkg.sv
`timescale 1ns / 1ps

package ffb_pkg;

  localparam int FrameBytes   = 32;
  localparam int PayloadBytes = 26;
  localparam int PayloadBits  = PayloadBytes * 8;
  localparam int CntWidth     = $clog2(PayloadBytes);
  localparam int PcWidth      = 3;

  localparam logic [7:0] Head0     = 8'h5A;
  localparam logic [7:0] Head1     = 8'hA5;
  localparam logic [7:0] FrameType = 8'h02;
  localparam logic [7:0] FrameLen  = 8'h1A;

  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'hA001;

  // field limits
  localparam logic signed [31:0] CurMin      = -32'sd2000;
  localparam logic signed [31:0] CurMax      = 32'sd2000;
  localparam logic signed [31:0] MposMax     = 32'sd2097151;
  localparam logic signed [31:0] MspdMax     = 32'sd40000;
  localparam logic signed [31:0] PosMaxPend  = 32'sd131071;
  localparam logic signed [31:0] PosMaxRuler = 32'sd1048575;
  localparam logic signed [31:0] SpdMax      = 32'sd4000;
  localparam logic signed [31:0] MvMax       = 32'sd20000;
  localparam logic signed [31:0] AdcMax      = 32'sd4095;

  typedef enum logic [2:0] {
    SRC_HEAD0,
    SRC_HEAD1,
    SRC_TYPE,
    SRC_LEN,
    SRC_PAYLOAD,
    SRC_CRC_LO,
    SRC_CRC_HI
  } src_t;

  typedef struct packed {
    src_t src;
    logic crc_en;  // fold the byte into the CRC
    logic last;    // mark beat as end of frame
    logic loop;    // repeat this step until payload count runs out
    logic done;    // program ends after this step
  } ucode_t;

  typedef logic [PcWidth-1:0] pc_t;

  localparam pc_t PcHead0   = 3'd0;
  localparam pc_t PcHead1   = 3'd1;
  localparam pc_t PcType    = 3'd2;
  localparam pc_t PcLen     = 3'd3;
  localparam pc_t PcPayload = 3'd4;
  localparam pc_t PcCrcLo   = 3'd5;
  localparam pc_t PcCrcHi   = 3'd6;

  // control store
  function automatic ucode_t ucode(input pc_t pc);
    ucode_t w;
    w = '{src: SRC_HEAD0, crc_en: 1'b0, last: 1'b0, loop: 1'b0, done: 1'b1};
    unique case (pc)
      PcHead0:   w = '{src: SRC_HEAD0,   crc_en: 1'b1, last: 1'b0, loop: 1'b0, done: 1'b0};
      PcHead1:   w = '{src: SRC_HEAD1,   crc_en: 1'b1, last: 1'b0, loop: 1'b0, done: 1'b0};
      PcType:    w = '{src: SRC_TYPE,    crc_en: 1'b1, last: 1'b0, loop: 1'b0, done: 1'b0};
      PcLen:     w = '{src: SRC_LEN,     crc_en: 1'b1, last: 1'b0, loop: 1'b0, done: 1'b0};
      PcPayload: w = '{src: SRC_PAYLOAD, crc_en: 1'b1, last: 1'b0, loop: 1'b1, done: 1'b0};
      PcCrcLo:   w = '{src: SRC_CRC_LO,  crc_en: 1'b0, last: 1'b0, loop: 1'b0, done: 1'b0};
      PcCrcHi:   w = '{src: SRC_CRC_HI,  crc_en: 1'b0, last: 1'b1, loop: 1'b0, done: 1'b1};
      default:   w = '{src: SRC_HEAD0,   crc_en: 1'b0, last: 1'b0, loop: 1'b0, done: 1'b1};
    endcase
    return w;
  endfunction

  // CRC16-Modbus, one byte, reflected
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// File: rtl/feedback_frame_builder.sv
`timescale 1ns / 1ps

// Telemetry frame builder. One sample beat on s_* is range checked against
// limits picked by control_object (0 inverted pendulum, 1 soft ruler). A bad
// sample yields a single beat {byte 0, tlast 1, tuser 1}. A good sample
// yields a 32-beat frame on m_*: 5A A5 02 1A, the 26 payload bytes
// little-endian in input field order, then CRC16-Modbus (init FFFF, poly
// A001 reflected) low byte first; tlast marks the final beat, tuser 0.
// Operation: the sample is taken, then a 7-step microprogram (payload step
// looping 26 times) emits one byte per cycle into the output register when
// m_tready does not stall it. The CRC is folded in byte by byte as the
// bytes go out. s_tready is high only while no frame is being emitted.
// Write cfg_* only when idle.
module feedback_frame_builder (
  input  logic                           clk,
  input  logic                           rst,
  // config
  input  logic                           cfg_wen,
  input  logic                           cfg_wdata,   // control_object
  // sample input
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // s_tdata fields, low bit up: motor_current[15:0], motor_position[31:0],
  // motor_speed[31:0], axis_position[31:0], axis_speed[31:0],
  // swing_position[31:0], swing_speed[31:0]
  input  logic [ffb_pkg::PayloadBits-1:0] s_tdata,
  // frame output
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [7:0]                     m_tdata,     // out_byte
  output logic                           m_tlast,     // last
  output logic                           m_tuser      // status
);

  logic control_object;

  // sequencer state
  logic                        busy;
  ffb_pkg::pc_t                pc;
  logic [ffb_pkg::CntWidth-1:0] cnt;
  logic [15:0]                 crc;
  logic [ffb_pkg::PayloadBits-1:0] payload;  // shifts down one byte per payload step

  ffb_pkg::ucode_t cw;
  logic            s_fire;
  logic            advance;
  logic            sample_ok;
  logic [7:0]      byte_sel;
  logic [15:0]     crc_next;
  logic            loop_more;

  // field views
  logic signed [15:0] cur;
  logic signed [31:0] mpos, mspd, apos, aspd, spos, sspd;

  assign cur  = $signed(s_tdata[15:0]);
  assign mpos = $signed(s_tdata[47:16]);
  assign mspd = $signed(s_tdata[79:48]);
  assign apos = $signed(s_tdata[111:80]);
  assign aspd = $signed(s_tdata[143:112]);
  assign spos = $signed(s_tdata[175:144]);
  assign sspd = $signed(s_tdata[207:176]);

  always_comb begin
    logic ok_fixed;
    logic ok_mode;
    ok_fixed = (32'(cur) >= ffb_pkg::CurMin) && (32'(cur) <= ffb_pkg::CurMax)
            && (mpos >= 32'sd0) && (mpos <= ffb_pkg::MposMax)
            && (mspd >= -ffb_pkg::MspdMax) && (mspd <= ffb_pkg::MspdMax)
            && (aspd >= -ffb_pkg::SpdMax) && (aspd <= ffb_pkg::SpdMax)
            && (apos >= 32'sd0);
    if (control_object) begin
      ok_mode = (apos <= ffb_pkg::PosMaxRuler)
             && (spos >= -ffb_pkg::MvMax) && (spos <= ffb_pkg::MvMax)
             && (sspd >= 32'sd0) && (sspd <= ffb_pkg::AdcMax);
    end else begin
      ok_mode = (apos <= ffb_pkg::PosMaxPend)
             && (spos >= 32'sd0) && (spos <= ffb_pkg::PosMaxPend)
             && (sspd >= -ffb_pkg::SpdMax) && (sspd <= ffb_pkg::SpdMax);
    end
    sample_ok = ok_fixed && ok_mode;
  end

  // take a sample only when idle and the output register can take a beat
  assign s_tready = !busy && (!m_tvalid || m_tready);
  assign s_fire   = s_tvalid && s_tready;
  assign advance  = busy && (!m_tvalid || m_tready);

  assign cw = ffb_pkg::ucode(pc);

  always_comb begin
    unique case (cw.src)
      ffb_pkg::SRC_HEAD0:   byte_sel = ffb_pkg::Head0;
      ffb_pkg::SRC_HEAD1:   byte_sel = ffb_pkg::Head1;
      ffb_pkg::SRC_TYPE:    byte_sel = ffb_pkg::FrameType;
      ffb_pkg::SRC_LEN:     byte_sel = ffb_pkg::FrameLen;
      ffb_pkg::SRC_PAYLOAD: byte_sel = payload[7:0];
      ffb_pkg::SRC_CRC_LO:  byte_sel = crc[7:0];
      ffb_pkg::SRC_CRC_HI:  byte_sel = crc[15:8];
      default:              byte_sel = 8'h00;
    endcase
  end

  assign crc_next  = cw.crc_en ? ffb_pkg::crc_byte(crc, byte_sel) : crc;
  // conditional jump: stay on the payload step until all bytes are out
  assign loop_more = cw.loop && (cnt != ffb_pkg::CntWidth'(ffb_pkg::PayloadBytes - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      control_object <= 1'b0;
    end else if (cfg_wen) begin
      control_object <= cfg_wdata;
    end
  end

  // sequencer control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pc   <= ffb_pkg::PcHead0;
      cnt  <= '0;
      crc  <= ffb_pkg::CrcInit;
    end else if (s_fire && sample_ok) begin
      busy <= 1'b1;
      pc   <= ffb_pkg::PcHead0;
      cnt  <= '0;
      crc  <= ffb_pkg::CrcInit;
    end else if (advance) begin
      crc <= crc_next;
      if (cw.done) begin
        busy <= 1'b0;
        pc   <= ffb_pkg::PcHead0;
      end else if (loop_more) begin
        cnt <= cnt + 1'b1;
      end else begin
        pc <= pc + 1'b1;
      end
    end
  end

  // payload capture and byte shift
  always_ff @(posedge clk) begin
    if (s_fire) begin
      payload <= s_tdata;
    end else if (advance && cw.src == ffb_pkg::SRC_PAYLOAD) begin
      payload <= payload >> 8;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if ((s_fire && !sample_ok) || advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire && !sample_ok) begin
      m_tdata <= 8'h00;
      m_tlast <= 1'b1;
      m_tuser <= 1'b1;
    end else if (advance) begin
      m_tdata <= byte_sel;
      m_tlast <= cw.last;
      m_tuser <= 1'b0;
    end
  end

endmodule

// File: bench/tb_feedback_frame_builder.sv
`timescale 1ns / 1ps

module tb_feedback_frame_builder;

  // Field limits per the telemetry spec
  localparam longint CUR_LIM       = 2000;
  localparam longint MPOS_HI       = 2097151;
  localparam longint MSPD_LIM      = 40000;
  localparam longint POS_HI_PEND   = 131071;   // axis and swing position, pendulum
  localparam longint APOS_HI_RULER = 1048575;
  localparam longint SPD_LIM       = 4000;
  localparam longint MV_LIM        = 20000;    // swing millivolts, soft ruler
  localparam longint ADC_HI        = 4095;     // 12-bit ADC code, soft ruler
  localparam longint MIN32         = -64'sd2147483648;
  localparam longint MAX32         = 64'sd2147483647;

  localparam logic [7:0] SYNC0     = 8'h5A;
  localparam logic [7:0] SYNC1     = 8'hA5;
  localparam logic [7:0] MSG_TYPE  = 8'h02;
  localparam logic [7:0] MSG_LEN   = 8'h1A;
  localparam int         FRAME_LEN = 32;
  localparam int         BODY_LEN  = 26;

  localparam bit MODE_PEND  = 1'b0;
  localparam bit MODE_RULER = 1'b1;

  localparam int DRAIN_CYCLES = 4;     // block idle again well within this
  localparam int END_CYCLES   = 40;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int CHUNKS       = 6;
  localparam int CHUNK_ITEMS  = 13;

  // Packed so the first field lands in the low bits of s_tdata
  typedef struct packed {
    logic signed [31:0] swing_speed;
    logic signed [31:0] swing_position;
    logic signed [31:0] axis_speed;
    logic signed [31:0] axis_position;
    logic signed [31:0] motor_speed;
    logic signed [31:0] motor_position;
    logic signed [15:0] motor_current;
  } sample_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       status;
  } beat_t;

  // How a directed row gets its expectation
  typedef enum logic {
    CHECK_PREDICT,   // frame bytes from the predictor
    CHECK_REJECT     // typed in: single error beat
  } check_t;

  typedef struct {
    sample_t smp;
    bit      mode;
    check_t  kind;
  } row_t;

  logic                            clk = 1'b0;
  logic                            rst;
  logic                            cfg_wen;
  logic                            cfg_wdata;
  logic                            s_tvalid;
  logic                            s_tready;
  logic [ffb_pkg::PayloadBits-1:0] s_tdata;
  logic                            m_tvalid;
  logic                            m_tready;
  logic [7:0]                      m_tdata;
  logic                            m_tlast;
  logic                            m_tuser;

  beat_t beats_due[$];    // expected output beats, oldest first
  row_t  sample_table[$];
  bit    mode_now;        // control_object as last written
  int    mismatches  = 0;
  int    cycle_count = 0;
  int    src_pct     = 0; // chance of an input gap before a sample
  int    sink_pct    = 0; // chance of a stall burst on the output
  int    sink_hold   = 0;

  feedback_frame_builder uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------

  function automatic bit in_span(longint v, longint lo, longint hi);
    return v >= lo && v <= hi;
  endfunction

  function automatic bit sample_ok(sample_t s, bit mode);
    bit ok;
    ok = in_span(s.motor_current, -CUR_LIM, CUR_LIM)
      && in_span(s.motor_position, 0, MPOS_HI)
      && in_span(s.motor_speed, -MSPD_LIM, MSPD_LIM)
      && in_span(s.axis_position, 0, mode ? APOS_HI_RULER : POS_HI_PEND)
      && in_span(s.axis_speed, -SPD_LIM, SPD_LIM);
    // last two fields change meaning with the mode
    if (mode == MODE_PEND)
      ok = ok && in_span(s.swing_position, 0, POS_HI_PEND)
              && in_span(s.swing_speed, -SPD_LIM, SPD_LIM);
    else
      ok = ok && in_span(s.swing_position, -MV_LIM, MV_LIM)
              && in_span(s.swing_speed, 0, ADC_HI);
    return ok;
  endfunction

  // CRC16-Modbus: init FFFF, reflected poly A001, one byte at a time
  function automatic logic [15:0] crc16_modbus_step(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++)
      c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
    return c;
  endfunction

  function automatic void queue_reject_beat();
    beats_due.push_back('{data: 8'h00, last: 1'b1, status: 1'b1});
  endfunction

  // Expected beats for one accepted sample under the given mode
  function automatic void queue_frame_beats(sample_t smp, bit mode);
    logic [ffb_pkg::PayloadBits-1:0] body;
    logic [7:0]                      frame [FRAME_LEN];
    logic [15:0]                     crc;
    if (!sample_ok(smp, mode)) begin
      queue_reject_beat();
      return;
    end
    body     = smp;
    frame[0] = SYNC0;
    frame[1] = SYNC1;
    frame[2] = MSG_TYPE;
    frame[3] = MSG_LEN;
    // payload is the sample itself, little-endian, first field first
    for (int k = 0; k < BODY_LEN; k++)
      frame[4 + k] = body[8 * k +: 8];
    crc = 16'hFFFF;
    for (int k = 0; k < FRAME_LEN - 2; k++)
      crc = crc16_modbus_step(crc, frame[k]);
    frame[FRAME_LEN - 2] = crc[7:0];
    frame[FRAME_LEN - 1] = crc[15:8];
    for (int k = 0; k < FRAME_LEN; k++)
      beats_due.push_back('{data: frame[k], last: k == FRAME_LEN - 1, status: 1'b0});
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------

  function automatic sample_t raw_sample();
    logic [ffb_pkg::PayloadBits-1:0] v;
    for (int k = 0; k < ffb_pkg::PayloadBits; k += 32)
      v[k +: 32] = $urandom;
    return v;
  endfunction

  // In range: mostly uniform, often an edge. Out of range: just past an
  // edge, or anywhere the field width allows outside the span.
  function automatic longint field_pick(longint lo, longint hi, bit outside, int width);
    logic signed [31:0] w32;
    logic signed [15:0] w16;
    longint             v;
    if (!outside) begin
      case ($urandom_range(7))
        0:       return lo;
        1:       return hi;
        default: return lo + longint'($urandom_range(32'(hi - lo), 0));
      endcase
    end
    case ($urandom_range(3))
      0:       return lo - 1;
      1:       return hi + 1;
      default: begin
        do begin
          w32 = $urandom;
          w16 = w32[15:0];
          v   = (width == 16) ? longint'(w16) : longint'(w32);
        end while (in_span(v, lo, hi));
        return v;
      end
    endcase
  endfunction

  // Mostly good samples with random content; the rest has one field off
  // its range or is raw noise over the whole word.
  function automatic sample_t random_sample(bit mode);
    sample_t s;
    int      shape;
    int      bad;
    shape = $urandom_range(99);
    if (shape >= 85)
      return raw_sample();
    bad = (shape >= 65) ? $urandom_range(6) : -1;
    s.motor_current  = 16'(field_pick(-CUR_LIM, CUR_LIM, bad == 0, 16));
    s.motor_position = 32'(field_pick(0, MPOS_HI, bad == 1, 32));
    s.motor_speed    = 32'(field_pick(-MSPD_LIM, MSPD_LIM, bad == 2, 32));
    s.axis_position  = 32'(field_pick(0, mode ? APOS_HI_RULER : POS_HI_PEND, bad == 3, 32));
    s.axis_speed     = 32'(field_pick(-SPD_LIM, SPD_LIM, bad == 4, 32));
    if (mode == MODE_PEND) begin
      s.swing_position = 32'(field_pick(0, POS_HI_PEND, bad == 5, 32));
      s.swing_speed    = 32'(field_pick(-SPD_LIM, SPD_LIM, bad == 6, 32));
    end else begin
      s.swing_position = 32'(field_pick(-MV_LIM, MV_LIM, bad == 5, 32));
      s.swing_speed    = 32'(field_pick(0, ADC_HI, bad == 6, 32));
    end
    return s;
  endfunction

  task automatic add_row(input bit m, input check_t kind, input longint cur,
                         input longint mpos, input longint mspd, input longint apos,
                         input longint aspd, input longint spos, input longint sspd);
    row_t r;
    r.smp.motor_current  = 16'(cur);
    r.smp.motor_position = 32'(mpos);
    r.smp.motor_speed    = 32'(mspd);
    r.smp.axis_position  = 32'(apos);
    r.smp.axis_speed     = 32'(aspd);
    r.smp.swing_position = 32'(spos);
    r.smp.swing_speed    = 32'(sspd);
    r.mode = m;
    r.kind = kind;
    sample_table.push_back(r);
  endtask

  // Drive one sample beat, hold it until taken, then book its expectation.
  // Returns in the step of acceptance with s_tvalid still high.
  task automatic push_sample(input sample_t smp, input check_t kind);
    if (src_pct != 0 && $urandom_range(99) < src_pct) begin
      s_tvalid <= 1'b0;
      s_tdata  <= raw_sample();   // junk while not valid
      repeat ($urandom_range(12, 1)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= smp;
    do @(posedge clk); while (!s_tready);
    if (kind == CHECK_REJECT)
      queue_reject_beat();
    else
      queue_frame_beats(smp, mode_now);
  endtask

  // Mode change only with the block idle: all beats out, then a short pause
  task automatic set_mode(input bit m);
    s_tvalid <= 1'b0;
    while (beats_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_wen   <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_wen  <= 1'b0;
    mode_now  = m;
  endtask

  // ---------------------------------------------------------------------
  // Output side: random stall bursts on m_tready, and checking
  // ---------------------------------------------------------------------

  always @(posedge clk) begin
    if (sink_hold != 0) begin
      m_tready  <= 1'b0;
      sink_hold <= sink_hold - 1;
    end else if (sink_pct != 0 && $urandom_range(99) < sink_pct) begin
      m_tready  <= 1'b0;
      sink_hold <= $urandom_range(11, 0);
    end else begin
      m_tready <= 1'b1;
    end
  end

  task automatic check_beat();
    beat_t got;
    beat_t want;
    got = '{data: m_tdata, last: m_tlast, status: m_tuser};
    if (beats_due.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected beat: data %h last %b status %b",
                 got.data, got.last, got.status);
      return;
    end
    want = beats_due.pop_front();
    if (got.data !== want.data || got.last !== want.last || got.status !== want.status) begin
      mismatches++;
      if (mismatches <= 10)
        $display("beat mismatch: expected data %h last %b status %b, got %h %b %b",
                 want.data, want.last, want.status, got.data, got.last, got.status);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      check_beat();
  end

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------

  initial begin
    rst       <= 1'b1;
    cfg_wen   <= 1'b0;
    cfg_wdata <= 1'b0;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    m_tready  <= 1'b0;
    mode_now   = MODE_PEND;

    // Directed rows. Rejects are typed in; good frames go to the predictor.
    //      mode        check          cur     mpos     mspd     apos     aspd   spos   sspd
    add_row(MODE_PEND,  CHECK_PREDICT, 0,      0,       0,       0,       0,     0,     0);
    add_row(MODE_PEND,  CHECK_PREDICT, 2000,   2097151, 40000,   131071,  4000,  131071, 4000);
    add_row(MODE_PEND,  CHECK_PREDICT, -2000,  0,       -40000,  0,       -4000, 0,     -4000);
    add_row(MODE_PEND,  CHECK_REJECT,  2001,   0,       0,       0,       0,     0,     0);
    add_row(MODE_PEND,  CHECK_REJECT,  -2001,  0,       0,       0,       0,     0,     0);
    add_row(MODE_PEND,  CHECK_REJECT,  0,      -1,      0,       0,       0,     0,     0);
    add_row(MODE_PEND,  CHECK_REJECT,  0,      2097152, 0,       0,       0,     0,     0);
    add_row(MODE_PEND,  CHECK_REJECT,  0,      0,       40001,   0,       0,     0,     0);
    add_row(MODE_PEND,  CHECK_REJECT,  0,      0,       -40001,  0,       0,     0,     0);
    add_row(MODE_PEND,  CHECK_REJECT,  0,      0,       0,       131072,  0,     0,     0);
    add_row(MODE_PEND,  CHECK_REJECT,  0,      0,       0,       0,       -4001, 0,     0);
    add_row(MODE_PEND,  CHECK_REJECT,  0,      0,       0,       0,       0,     -1,    0);
    add_row(MODE_PEND,  CHECK_REJECT,  0,      0,       0,       0,       0,     0,     4001);
    add_row(MODE_PEND,  CHECK_REJECT,  -32768, MIN32,   MIN32,   MIN32,   MIN32, MIN32, MIN32);
    add_row(MODE_PEND,  CHECK_REJECT,  32767,  MAX32,   MAX32,   MAX32,   MAX32, MAX32, MAX32);
    // soft ruler: wider axis span, swing fields are millivolts and ADC code
    add_row(MODE_RULER, CHECK_PREDICT, 2000,   2097151, 40000,   1048575, 4000,  20000, 4095);
    add_row(MODE_RULER, CHECK_PREDICT, -2000,  0,       -40000,  0,       -4000, -20000, 0);
    add_row(MODE_RULER, CHECK_PREDICT, 0,      0,       0,       131072,  0,     -1,    4000);
    add_row(MODE_RULER, CHECK_REJECT,  0,      0,       0,       1048576, 0,     0,     0);
    add_row(MODE_RULER, CHECK_REJECT,  0,      0,       0,       0,       0,     20001, 0);
    add_row(MODE_RULER, CHECK_REJECT,  0,      0,       0,       0,       0,     -20001, 0);
    add_row(MODE_RULER, CHECK_REJECT,  0,      0,       0,       0,       0,     0,     -1);
    add_row(MODE_RULER, CHECK_REJECT,  0,      0,       0,       0,       0,     0,     4096);
    add_row(MODE_RULER, CHECK_REJECT,  0,      0,       0,       0,       0,     0,     -4000);

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // register comes out of reset as pendulum; write it anyway
    set_mode(MODE_PEND);
    src_pct  = 20;
    sink_pct = 10;
    foreach (sample_table[i]) begin
      if (sample_table[i].mode != mode_now)
        set_mode(sample_table[i].mode);
      push_sample(sample_table[i].smp, sample_table[i].kind);
    end

    // Random phases, alternating mode; idle rates vary per phase, last is clean
    for (int c = 0; c < CHUNKS; c++) begin
      set_mode(c[0] ? MODE_RULER : MODE_PEND);
      if (c == CHUNKS - 1) begin
        src_pct  = 0;
        sink_pct = 0;
      end else begin
        case ($urandom_range(2))
          0:       src_pct = 0;
          1:       src_pct = 15;
          default: src_pct = 40;
        endcase
        case ($urandom_range(2))
          0:       sink_pct = 0;
          1:       sink_pct = 5;
          default: sink_pct = 20;
        endcase
      end
      for (int n = 0; n < CHUNK_ITEMS; n++)
        push_sample(random_sample(mode_now), CHECK_PREDICT);
    end

    s_tvalid <= 1'b0;
    while (beats_due.size() != 0) @(posedge clk);
    repeat (END_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
